### design/wzad_pkg.sv
// Shared types, sizes and codes for the windowed z-score anomaly detector.
// No dependencies; every other design file imports this package.
package wzad_pkg;

	localparam int NUM_METRICS = 8;
	localparam int WINDOW      = 1000;
	localparam int MIN_SAMPLES = 100;
	localparam int SAMPLE_BITS = 24;

	localparam int ID_W       = 3;
	localparam int X_W        = 24;
	localparam int MEAN_W     = 32;
	localparam int SCORE_W    = 9;
	localparam int CAUSE_W    = 2;
	localparam int KINDS_W    = 16;
	localparam int CNT_W      = $clog2(WINDOW + 1);
	localparam int POS_W      = $clog2(WINDOW);
	localparam int RING_DEPTH = NUM_METRICS * WINDOW;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int SUM_W      = X_W + CNT_W;
	localparam int SQ_W       = 2 * X_W + CNT_W;
	localparam int DEV_W      = SUM_W + 1;
	localparam int FRAC_W     = 8;
	localparam int DIVD_W     = SUM_W + FRAC_W;
	localparam int PROD_W     = 96;
	localparam int MB_W       = 40;
	localparam int MD_W       = 8;
	localparam int SCORE_ONE  = 256;

	typedef enum logic [1:0] {
		KIND_OTHER,
		KIND_LATENCY,
		KIND_ERROR,
		KIND_MEMORY
	} kind_t;

	typedef enum logic [CAUSE_W-1:0] {
		CAUSE_UNUSUAL,
		CAUSE_PERF,
		CAUSE_ERROR,
		CAUSE_MEMORY
	} cause_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_UPD,
		S_NX,
		S_DEV,
		S_MNQ,
		S_MSS,
		S_MDD,
		S_TEST,
		S_SQ,
		S_SMUL,
		S_SWAIT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]        metric_id;
		logic signed [X_W-1:0]  sample;
	} in_item_t;

	typedef struct packed {
		logic                     is_anomaly;
		logic [ID_W-1:0]          metric_out;
		logic signed [X_W-1:0]    observed;
		logic signed [MEAN_W-1:0] expected_mean;
		logic [SCORE_W-1:0]       score;
		logic [CAUSE_W-1:0]       cause;
		logic [9:0]               samples_held;
	} out_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
		logic [CNT_W-1:0] cnt;
		logic [POS_W-1:0] pos;
	} st_entry_t;

endpackage

### design/wzad_mul.sv
// Shared multiplier: consumes one 8-bit digit of b per cycle, shift-and-add.
// Depends on wzad_pkg for product and operand widths.
module wzad_mul import wzad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] a,
	input  logic [MB_W-1:0]   b,
	output logic              busy,
	output logic [PROD_W-1:0] prod
);

	logic              busy_q;
	logic [PROD_W-1:0] a_q;
	logic [MB_W-1:0]   b_q;
	logic [PROD_W-1:0] acc_q;
	logic [MB_W-1:0]   b_nxt;

	assign b_nxt = b_q >> MD_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_nxt == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + a_q * PROD_W'(b_q[MD_W-1:0]);
			a_q   <= a_q << MD_W;
			b_q   <= b_nxt;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

### design/wzad_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on wzad_pkg for dividend and count widths.
module wzad_div import wzad_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              busy,
	output logic [DIVD_W-1:0] quotient
);

	localparam int DC_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic [DC_W-1:0]   cnt_q;
	logic [DIVD_W-1:0] q_q;
	logic [CNT_W:0]    r_q;
	logic [CNT_W-1:0]  d_q;
	logic [CNT_W:0]    r_sh;
	logic              fits;

	assign r_sh = {r_q[CNT_W-1:0], q_q[DIVD_W-1]};
	assign fits = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DC_W'(DIVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DC_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= fits ? r_sh - {1'b0, d_q} : r_sh;
			q_q <= {q_q[DIVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = q_q;

endmodule

### design/window_zscore_anomaly_detector_core.sv
// Windowed z-score anomaly detector: one item in, one result out. Each sample
// updates its metric's window (ring memory plus a small memory of running sum,
// sum of squares, count and write position) and is tested against 3 sigma.
// The mean comes from the bit-serial divider; an anomaly that needs its score
// searched also runs a binary search, each round on the shared 8-bit-digit
// multiplier. One item is in flight at a time; the next is taken while the
// previous result still waits on the output register.
// Depends on wzad_pkg, wzad_mul and wzad_div.
module window_zscore_anomaly_detector_core import wzad_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               samp_valid,
	output logic               samp_stall,
	input  in_item_t           samp,
	output logic               res_valid,
	input  logic               res_stall,
	output out_item_t          res,
	input  logic               cfg_we,
	input  logic [KINDS_W-1:0] cfg_wdata
);

	state_t state_q, nxt;

	logic [KINDS_W-1:0]     kinds_q;
	logic                   res_valid_q;
	out_item_t              res_q;
	logic [NUM_METRICS-1:0] st_vld_q;

	// memories
	logic [X_W-1:0] ring_mem [0:RING_DEPTH-1];
	st_entry_t      st_mem   [0:NUM_METRICS-1];
	logic [X_W-1:0] ring_rd_q;
	st_entry_t      st_rd_q;
	logic           stv_q;
	logic [ID_W-1:0]    st_addr;
	logic [RING_AW-1:0] ring_addr;

	// item registers
	logic [ID_W-1:0]         id_q;
	logic signed [X_W-1:0]   x_q;
	logic                    bad_q;
	st_entry_t               st_q;
	logic                    full_q;
	logic [POS_W-1:0]        pos_q;
	logic [RING_AW-1:0]      slot_q;
	logic signed [2*X_W-1:0] xsq_q;
	logic signed [2*X_W-1:0] oldsq_q;
	logic signed [X_W-1:0]   old_q;
	logic [CNT_W-1:0]        n_q;
	logic signed [SUM_W-1:0] s_q;
	logic [SQ_W-1:0]         q_q;
	logic signed [DEV_W-1:0] nx_q;
	logic signed [DEV_W-1:0] dev_q;
	logic [DEV_W-1:0]        d_q;
	logic [SUM_W-1:0]        smag_q;
	logic [PROD_W-1:0]       nq_q;
	logic [PROD_W-1:0]       var_q;
	logic [PROD_W-1:0]       d2_q;
	logic [PROD_W-1:0]       v100_q;
	logic [SCORE_W-1:0]      lo_q, hi_q, mid_q, score_q;
	logic [MB_W-1:0]         midsq_q;
	logic                    anom_q;

	// combinational
	logic                    accept;
	logic                    id_bad;
	logic signed [X_W-1:0]   x_sh, x_c;
	st_entry_t               st_e;
	logic [POS_W-1:0]        pos_fix;
	logic [RING_AW-1:0]      slot_c;
	logic signed [SUM_W-1:0] old_e, x_e, sum_old, sum_new;
	logic [SQ_W-1:0]         sq_new;
	logic [CNT_W-1:0]        cnt_new;
	logic [POS_W-1:0]        pos_new;
	logic signed [DEV_W-1:0] nx_c, dev_c;
	logic [SUM_W-1:0]        smag_c;
	logic [PROD_W-1:0]       var9;
	logic [PROD_W-1:0]       var100;
	logic [SCORE_W:0]        mid_sum;
	logic [SCORE_W-1:0]      mid_c;
	logic [DIVD_W-1:0]       mean_neg;
	logic [DIVD_W-1:0]       mean_c;
	logic signed [DEV_W+1:0] two_nx, s_e, three_s;
	kind_t                   kind;
	cause_t                  cause_c;

	logic              mul_start, mul_busy;
	logic [PROD_W-1:0] mul_a, mul_prod;
	logic [MB_W-1:0]   mul_b;
	logic              div_start, div_busy;
	logic [DIVD_W-1:0] div_q;

	wzad_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	wzad_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({smag_q, FRAC_W'(0)}),
		.divisor  (n_q),
		.busy     (div_busy),
		.quotient (div_q)
	);

	assign samp_stall = (state_q != S_IDLE);
	assign accept     = samp_valid && (state_q == S_IDLE);
	assign id_bad     = 32'(samp.metric_id) >= NUM_METRICS;

	// sign-extend from SAMPLE_BITS
	assign x_sh = samp.sample <<< (X_W - SAMPLE_BITS);
	assign x_c  = x_sh >>> (X_W - SAMPLE_BITS);

	assign st_e    = stv_q ? st_rd_q : '0;
	assign pos_fix = (32'(st_e.pos) >= WINDOW) ? '0 : st_e.pos;
	assign slot_c  = RING_AW'(32'(id_q) * WINDOW + 32'(pos_fix));

	assign st_addr   = accept ? samp.metric_id : id_q;
	assign ring_addr = (state_q == S_RD1) ? slot_c : slot_q;

	assign old_e   = SUM_W'(old_q);
	assign x_e     = SUM_W'(x_q);
	assign sum_old = st_q.sum;
	assign sum_new = sum_old - (full_q ? old_e : '0) + x_e;
	assign sq_new  = st_q.sq - (full_q ? SQ_W'(unsigned'(oldsq_q)) : '0)
		+ SQ_W'(unsigned'(xsq_q));
	assign cnt_new = full_q ? st_q.cnt : st_q.cnt + 1'b1;
	assign pos_new = (32'(pos_q) + 1 >= WINDOW) ? '0 : pos_q + 1'b1;

	assign nx_c   = $signed({1'b0, n_q}) * x_q;
	assign dev_c  = nx_q - s_q;
	assign smag_c = s_q[SUM_W-1] ? -s_q : s_q;

	assign var9   = (var_q << 3) + var_q;
	assign var100 = (var_q << 6) + (var_q << 5) + (var_q << 2);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
	assign mid_c   = mid_sum[SCORE_W:1];

	assign mean_neg = -div_q;
	assign mean_c   = s_q[SUM_W-1] ? mean_neg : div_q;

	assign two_nx  = {nx_q[DEV_W-1], nx_q, 1'b0};
	assign s_e     = (DEV_W + 2)'(s_q);
	assign three_s = s_e + (s_e <<< 1);
	assign kind    = kind_t'(kinds_q[{id_q, 1'b0} +: 2]);

	always_comb begin
		cause_c = CAUSE_UNUSUAL;
		if (kind == KIND_LATENCY && dev_q > 0) begin
			cause_c = CAUSE_PERF;
		end else if (kind == KIND_ERROR && dev_q > 0) begin
			cause_c = CAUSE_ERROR;
		end else if (kind == KIND_MEMORY && two_nx > three_s) begin
			cause_c = CAUSE_MEMORY;
		end
	end

	// next state and unit controls
	always_comb begin
		nxt       = state_q;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (samp_valid) begin
					nxt = id_bad ? S_FIN : S_RD1;
				end
			end
			S_RD1: nxt = S_RD2;
			S_RD2: nxt = S_UPD;
			S_UPD: nxt = S_NX;
			S_NX:  nxt = S_DEV;
			S_DEV: begin
				div_start = 1'b1;
				mul_start = 1'b1;
				mul_a     = PROD_W'(q_q);
				mul_b     = MB_W'(n_q);
				nxt       = S_MNQ;
			end
			S_MNQ: begin
				if (!mul_busy) begin
					mul_start = 1'b1;
					mul_a     = PROD_W'(smag_q);
					mul_b     = MB_W'(smag_q);
					nxt       = S_MSS;
				end
			end
			S_MSS: begin
				if (!mul_busy) begin
					mul_start = 1'b1;
					mul_a     = PROD_W'(d_q);
					mul_b     = MB_W'(d_q);
					nxt       = S_MDD;
				end
			end
			S_MDD: begin
				if (!mul_busy) begin
					nxt = S_TEST;
				end
			end
			S_TEST: begin
				if (32'(n_q) >= MIN_SAMPLES && var_q != '0 && d2_q > var9) begin
					nxt = S_SQ;
				end else begin
					nxt = S_FIN;
				end
			end
			S_SQ:  nxt = (lo_q < hi_q) ? S_SMUL : S_FIN;
			S_SMUL: begin
				mul_start = 1'b1;
				mul_a     = v100_q;
				mul_b     = midsq_q;
				nxt       = S_SWAIT;
			end
			S_SWAIT: begin
				if (!mul_busy) begin
					nxt = S_SQ;
				end
			end
			S_FIN: begin
				if (!div_busy && (!res_valid_q || !res_stall)) begin
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kinds_q     <= '0;
			res_valid_q <= 1'b0;
			st_vld_q    <= '0;
		end else begin
			state_q <= nxt;
			if (cfg_we) begin
				kinds_q <= cfg_wdata;
			end
			if (state_q == S_UPD) begin
				st_vld_q[id_q] <= 1'b1;
			end
			if (state_q == S_FIN && nxt == S_IDLE) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			ring_mem[ring_addr] <= x_q;
		end
		ring_rd_q <= ring_mem[ring_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			st_mem[id_q] <= '{sum: sum_new, sq: sq_new, cnt: cnt_new, pos: pos_new};
		end
		st_rd_q <= st_mem[st_addr];
		stv_q   <= st_vld_q[st_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				id_q  <= samp.metric_id;
				x_q   <= x_c;
				bad_q <= id_bad;
			end
			S_RD1: begin
				st_q   <= st_e;
				full_q <= 32'(st_e.cnt) >= WINDOW;
				pos_q  <= pos_fix;
				slot_q <= slot_c;
				xsq_q  <= x_q * x_q;
			end
			S_RD2: begin
				old_q   <= ring_rd_q;
				oldsq_q <= $signed(ring_rd_q) * $signed(ring_rd_q);
			end
			S_UPD: begin
				n_q <= cnt_new;
				s_q <= sum_new;
				q_q <= sq_new;
			end
			S_NX: begin
				nx_q   <= nx_c;
				smag_q <= smag_c;
			end
			S_DEV: begin
				dev_q <= dev_c;
				d_q   <= dev_c[DEV_W-1] ? -dev_c : dev_c;
			end
			S_MNQ: begin
				if (!mul_busy) begin
					nq_q <= mul_prod;
				end
			end
			S_MSS: begin
				if (!mul_busy) begin
					var_q <= nq_q - mul_prod;
				end
			end
			S_MDD: begin
				if (!mul_busy) begin
					d2_q <= mul_prod;
				end
			end
			S_TEST: begin
				anom_q  <= 1'b0;
				score_q <= '0;
				lo_q    <= '0;
				hi_q    <= SCORE_W'(SCORE_ONE);
				v100_q  <= var100;
				if (32'(n_q) >= MIN_SAMPLES && var_q == '0) begin
					anom_q  <= d_q != '0;
					score_q <= SCORE_W'(SCORE_ONE);
				end
			end
			S_SQ: begin
				mid_q   <= mid_c;
				midsq_q <= MB_W'(mid_c) * MB_W'(mid_c);
				if (lo_q >= hi_q) begin
					anom_q  <= 1'b1;
					score_q <= lo_q;
				end
			end
			S_SWAIT: begin
				if (!mul_busy) begin
					// keep mid when 100*mid^2*var stays within 65536*dev^2
					if (mul_prod <= (d2_q << 16)) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q - 1'b1;
					end
				end
			end
			S_FIN: begin
				if (nxt == S_IDLE) begin
					res_q.metric_out <= id_q;
					res_q.observed   <= x_q;
					if (bad_q) begin
						res_q.is_anomaly    <= 1'b0;
						res_q.expected_mean <= '0;
						res_q.score         <= '0;
						res_q.cause         <= CAUSE_UNUSUAL;
						res_q.samples_held  <= '0;
					end else begin
						res_q.is_anomaly    <= anom_q;
						res_q.expected_mean <= MEAN_W'(mean_c);
						res_q.score         <= anom_q ? score_q : '0;
						res_q.cause         <= anom_q ? cause_c : CAUSE_UNUSUAL;
						res_q.samples_held  <= 10'(n_q);
					end
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier started while busy");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ) |-> (lo_q <= hi_q))
		else $error("score search bounds crossed");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && nxt == S_IDLE) |=> res_valid)
		else $error("finished item did not raise result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |=> (n_q != '0 && 32'(n_q) <= WINDOW))
		else $error("window count out of range");

endmodule
